[rtl/afs_pkg.sv]
// Shared types and constants for the animation frame sequencer.
// Item structs, command and state codes, register indexes and queue sizes.
// No dependencies.
package afs_pkg;

    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_TICK   = 3'd1;
    localparam logic [2:0] OP_RESUME = 3'd2;
    localparam logic [2:0] OP_PAUSE  = 3'd3;
    localparam logic [2:0] OP_STOP   = 3'd4;

    localparam logic [2:0] CFG_START_FRAME     = 3'd0;
    localparam logic [2:0] CFG_END_FRAME       = 3'd1;
    localparam logic [2:0] CFG_REPEAT_MODE     = 3'd2;
    localparam logic [2:0] CFG_PING_PONG       = 3'd3;
    localparam logic [2:0] CFG_BACKWARD        = 3'd4;
    localparam logic [2:0] CFG_CUSTOM_SPEED_ON = 3'd5;
    localparam logic [2:0] CFG_CUSTOM_INTERVAL = 3'd6;

    localparam logic [15:0] CUSTOM_INTERVAL_RST = 16'd100;

    localparam int CMD_Q_DEPTH = 2;
    localparam int OUT_Q_DEPTH = 4;
    localparam int OUT_CNT_W   = $clog2(OUT_Q_DEPTH + 1);

    typedef enum logic [1:0] {
        PS_IDLE      = 2'd0,
        PS_PLAYING   = 2'd1,
        PS_PAUSED    = 2'd2,
        PS_COMPLETED = 2'd3
    } t_play;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_TICK,
        CMD_RESUME,
        CMD_PAUSE,
        CMD_STOP
    } t_cmd_kind;

    typedef struct packed {
        logic [2:0]  op;
        logic [5:0]  load_index;
        logic [31:0] load_word0;
        logic [31:0] load_word1;
        logic [31:0] load_word2;
        logic [15:0] load_time;
    } t_in_item;

    typedef struct packed {
        logic        show;
        logic [31:0] pixel_word0;
        logic [31:0] pixel_word1;
        logic [31:0] pixel_word2;
        logic [1:0]  play_state;
        logic [5:0]  frame_now;
    } t_out_item;

    typedef struct packed {
        t_cmd_kind   kind;
        logic        slot_ok;
        logic [5:0]  load_index;
        logic [31:0] load_word0;
        logic [31:0] load_word1;
        logic [31:0] load_word2;
        logic [15:0] load_time;
    } t_cmd;

endpackage

[rtl/afs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
module afs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/afs_fifo.sv]
// Generic register-based queue with occupancy count.
// DEPTH must be a power of two. No dependencies.
module afs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

[rtl/afs_front.sv]
// Front end: decodes incoming items into commands and queues them.
// Depends on afs_pkg and afs_fifo.
module afs_front #(
    parameter int MAX_FRAMES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  afs_pkg::t_in_item i_item,
    output logic              o_full,
    output afs_pkg::t_cmd     o_cmd,
    output logic              o_cmd_valid,
    input  logic              i_cmd_take
);

    localparam int CMD_W = $bits(afs_pkg::t_cmd);

    afs_pkg::t_cmd       cmd;
    logic [CMD_W-1:0]    q_data;
    logic                q_empty;
    logic [$clog2(afs_pkg::CMD_Q_DEPTH+1)-1:0] q_count;

    always_comb begin
        cmd.slot_ok    = ({26'b0, i_item.load_index} < 32'(MAX_FRAMES));
        cmd.load_index = i_item.load_index;
        cmd.load_word0 = i_item.load_word0;
        cmd.load_word1 = i_item.load_word1;
        cmd.load_word2 = i_item.load_word2;
        cmd.load_time  = i_item.load_time;
        unique case (i_item.op)
            afs_pkg::OP_LOAD:   cmd.kind = afs_pkg::CMD_LOAD;
            afs_pkg::OP_TICK:   cmd.kind = afs_pkg::CMD_TICK;
            afs_pkg::OP_RESUME: cmd.kind = afs_pkg::CMD_RESUME;
            afs_pkg::OP_PAUSE:  cmd.kind = afs_pkg::CMD_PAUSE;
            afs_pkg::OP_STOP:   cmd.kind = afs_pkg::CMD_STOP;
            default:            cmd.kind = afs_pkg::CMD_NOP;
        endcase
    end

    afs_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (afs_pkg::CMD_Q_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_take),
        .o_data  (q_data),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    assign o_cmd       = afs_pkg::t_cmd'(q_data);
    assign o_cmd_valid = !q_empty && (q_count != '0);

endmodule

[rtl/afs_back.sv]
// Back end: player state, frame stores, tick stepping and result staging.
// Depends on afs_pkg and afs_ram.
module afs_back #(
    parameter int MAX_FRAMES = 64,
    parameter int TIME_BITS  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [2:0]                      i_cfg_index,
    input  logic [15:0]                     i_cfg_data,
    input  afs_pkg::t_cmd                   i_cmd,
    input  logic                            i_cmd_valid,
    output logic                            o_cmd_take,
    input  logic [afs_pkg::OUT_CNT_W-1:0]   i_out_count,
    output logic                            o_res_valid,
    output afs_pkg::t_out_item              o_res
);

    localparam int IDX_W = (MAX_FRAMES > 2) ? $clog2(MAX_FRAMES) : 1;
    localparam int SW    = ((IDX_W > 6) ? IDX_W : 6) + 2;
    localparam int CMP_W = (TIME_BITS > 16) ? TIME_BITS : 16;
    localparam int CRD_W = afs_pkg::OUT_CNT_W + 1;
    localparam logic signed [SW-1:0] ZERO_S = '0;
    localparam logic signed [SW-1:0] ONE_S  = SW'(1);
    localparam logic signed [SW-1:0] LAST_S = SW'(MAX_FRAMES - 1);
    localparam logic [TIME_BITS-1:0] SAT    = '1;

    logic [5:0]            r_start_frame;
    logic [5:0]            r_end_frame;
    logic                  r_repeat_mode;
    logic                  r_ping_pong;
    logic                  r_backward;
    logic                  r_custom_on;
    logic [15:0]           r_custom_interval;

    afs_pkg::t_play        r_state, n_state;
    logic [IDX_W-1:0]      r_frame, n_frame;
    logic [TIME_BITS-1:0]  r_elapsed, n_elapsed;
    logic                  r_bounce, n_bounce;
    logic                  r_loaded, n_loaded;

    logic                  r_s2_valid;
    logic                  r_s2_show;
    logic                  r_s2_pix;
    afs_pkg::t_play        r_s2_state;
    logic [IDX_W-1:0]      r_s2_frame;

    logic                  r_dur_byp_vld;
    logic [15:0]           r_dur_byp;

    logic                  take;
    logic                  ram_we;
    logic [IDX_W+5:0]      slot_ext;
    logic [IDX_W-1:0]      slot;
    logic [95:0]           pix_q;
    logic [15:0]           dur_q;
    logic [15:0]           dur_cur;
    logic [15:0]           interval;
    logic [TIME_BITS-1:0]  elapsed_inc;
    logic                  reached;
    logic                  tick_go;
    logic                  res_show;
    logic                  res_pix;

    logic signed [SW-1:0]  frame_s;
    logic signed [SW-1:0]  start_s;
    logic signed [SW-1:0]  end_s;
    logic signed [SW-1:0]  step_up;
    logic signed [SW-1:0]  step_dn;
    logic signed [SW-1:0]  adv_i;
    logic                  adv_done;
    logic                  adv_bounce;
    logic [IDX_W-1:0]      adv_frame;
    logic [IDX_W-1:0]      start_idx;
    logic [IDX_W+5:0]      fr_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_frame     <= '0;
            r_end_frame       <= '0;
            r_repeat_mode     <= 1'b0;
            r_ping_pong       <= 1'b0;
            r_backward        <= 1'b0;
            r_custom_on       <= 1'b0;
            r_custom_interval <= afs_pkg::CUSTOM_INTERVAL_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                afs_pkg::CFG_START_FRAME:     r_start_frame     <= i_cfg_data[5:0];
                afs_pkg::CFG_END_FRAME:       r_end_frame       <= i_cfg_data[5:0];
                afs_pkg::CFG_REPEAT_MODE:     r_repeat_mode     <= i_cfg_data[0];
                afs_pkg::CFG_PING_PONG:       r_ping_pong       <= i_cfg_data[0];
                afs_pkg::CFG_BACKWARD:        r_backward        <= i_cfg_data[0];
                afs_pkg::CFG_CUSTOM_SPEED_ON: r_custom_on       <= i_cfg_data[0];
                afs_pkg::CFG_CUSTOM_INTERVAL: r_custom_interval <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign take = i_cmd_valid &&
                  ((CRD_W'(i_out_count) + CRD_W'(r_s2_valid)) < CRD_W'(afs_pkg::OUT_Q_DEPTH));
    assign o_cmd_take = take;

    assign slot_ext = {{IDX_W{1'b0}}, i_cmd.load_index};
    assign slot     = slot_ext[IDX_W-1:0];

    afs_ram #(
        .WIDTH (96),
        .DEPTH (MAX_FRAMES)
    ) u_pixel_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (slot),
        .i_wdata ({i_cmd.load_word0, i_cmd.load_word1, i_cmd.load_word2}),
        .i_raddr (n_frame),
        .o_rdata (pix_q)
    );

    afs_ram #(
        .WIDTH (16),
        .DEPTH (MAX_FRAMES)
    ) u_dur_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (slot),
        .i_wdata (i_cmd.load_time),
        .i_raddr (n_frame),
        .o_rdata (dur_q)
    );

    // forward a duration written to the slot being read in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur_byp_vld <= 1'b0;
        end else begin
            r_dur_byp_vld <= ram_we && (slot == n_frame);
        end
        r_dur_byp <= i_cmd.load_time;
    end

    assign dur_cur     = r_dur_byp_vld ? r_dur_byp : dur_q;
    assign interval    = r_custom_on ? r_custom_interval : dur_cur;
    assign elapsed_inc = (r_elapsed == SAT) ? r_elapsed : r_elapsed + TIME_BITS'(1);
    assign reached     = CMP_W'(elapsed_inc) >= CMP_W'(interval);
    assign tick_go     = (r_state == afs_pkg::PS_PLAYING) && r_loaded;

    always_comb begin
        frame_s = $signed({{(SW-IDX_W){1'b0}}, r_frame});
        start_s = $signed({{(SW-6){1'b0}}, r_start_frame});
        end_s   = $signed({{(SW-6){1'b0}}, r_end_frame});
        if (start_s > LAST_S) begin
            start_s = LAST_S;
        end
        if (end_s > LAST_S) begin
            end_s = LAST_S;
        end
        start_idx = start_s[IDX_W-1:0];
        step_up   = frame_s + ONE_S;
        step_dn   = frame_s - ONE_S;
    end

    always_comb begin
        adv_done   = 1'b0;
        adv_bounce = r_bounce;
        if (!r_ping_pong) begin
            if (r_backward) begin
                adv_i = step_dn;
                if (adv_i <= start_s) begin
                    if (!r_repeat_mode) adv_done = 1'b1;
                    else                adv_i    = end_s;
                end
            end else begin
                adv_i = step_up;
                if (adv_i > end_s) begin
                    if (!r_repeat_mode) adv_done = 1'b1;
                    else                adv_i    = start_s;
                end
            end
        end else if (!r_bounce) begin
            adv_i = r_backward ? step_dn : step_up;
            if (adv_i >= end_s || adv_i <= start_s) begin
                adv_bounce = 1'b1;
                adv_i      = r_backward ? start_s : end_s;
            end
        end else begin
            adv_i = r_backward ? step_up : step_dn;
            if (adv_i <= start_s || adv_i >= end_s) begin
                adv_bounce = 1'b0;
                if (!r_repeat_mode) adv_done = 1'b1;
                else                adv_i    = r_backward ? end_s : start_s;
            end
        end
        if (adv_i < ZERO_S) begin
            adv_frame = '0;
        end else if (adv_i > LAST_S) begin
            adv_frame = LAST_S[IDX_W-1:0];
        end else begin
            adv_frame = adv_i[IDX_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        if (take) begin
            unique case (i_cmd.kind)
                afs_pkg::CMD_TICK: begin
                    if (tick_go && reached && adv_done) n_state = afs_pkg::PS_COMPLETED;
                end
                afs_pkg::CMD_RESUME: begin
                    if (r_state != afs_pkg::PS_PLAYING && r_loaded) begin
                        n_state = afs_pkg::PS_PLAYING;
                    end
                end
                afs_pkg::CMD_PAUSE: begin
                    if (r_state == afs_pkg::PS_PLAYING) n_state = afs_pkg::PS_PAUSED;
                end
                afs_pkg::CMD_STOP: begin
                    if (r_state != afs_pkg::PS_IDLE) n_state = afs_pkg::PS_IDLE;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_frame   = r_frame;
        n_elapsed = r_elapsed;
        n_bounce  = r_bounce;
        n_loaded  = r_loaded;
        ram_we    = 1'b0;
        res_show  = 1'b0;
        res_pix   = 1'b0;
        if (take) begin
            unique case (i_cmd.kind)
                afs_pkg::CMD_LOAD: begin
                    ram_we   = i_cmd.slot_ok;
                    n_loaded = 1'b1;
                end
                afs_pkg::CMD_TICK: begin
                    if (tick_go) begin
                        n_elapsed = elapsed_inc;
                        if (reached) begin
                            n_frame  = adv_frame;
                            n_bounce = adv_bounce;
                            res_show = 1'b1;
                            if (!adv_done) begin
                                n_elapsed = '0;
                                res_pix   = 1'b1;
                            end
                        end
                    end
                end
                afs_pkg::CMD_RESUME: begin
                    if (r_state != afs_pkg::PS_PLAYING && r_loaded) begin
                        if (r_state == afs_pkg::PS_IDLE) begin
                            n_frame  = start_idx;
                            n_bounce = 1'b0;
                        end
                        n_elapsed = '0;
                    end
                end
                afs_pkg::CMD_STOP: begin
                    if (r_state != afs_pkg::PS_IDLE) begin
                        n_loaded = 1'b0;
                        res_show = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= afs_pkg::PS_IDLE;
            r_frame    <= '0;
            r_elapsed  <= '0;
            r_bounce   <= 1'b0;
            r_loaded   <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_frame    <= n_frame;
            r_elapsed  <= n_elapsed;
            r_bounce   <= n_bounce;
            r_loaded   <= n_loaded;
            r_s2_valid <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_show  <= res_show;
        r_s2_pix   <= res_pix;
        r_s2_state <= n_state;
        r_s2_frame <= n_frame;
    end

    assign fr_ext = {6'b0, r_s2_frame};

    always_comb begin
        o_res.show        = r_s2_show;
        o_res.pixel_word0 = r_s2_pix ? pix_q[95:64] : 32'b0;
        o_res.pixel_word1 = r_s2_pix ? pix_q[63:32] : 32'b0;
        o_res.pixel_word2 = r_s2_pix ? pix_q[31:0]  : 32'b0;
        o_res.play_state  = r_s2_state;
        o_res.frame_now   = fr_ext[5:0];
    end

    assign o_res_valid = r_s2_valid;

endmodule

[rtl/animation_frame_sequencer_top.sv]
// Top level of the animation frame sequencer.
// Depends on afs_pkg, afs_front, afs_back and afs_fifo.
//
// Takes one item per clock while full is low and gives exactly one result per
// item, in order. An item is decoded into a short command queue, then executed
// by the single player stage that owns the frame index, elapsed counter and
// play state; its result is registered in a result stage and then enters the
// output queue, once the frame memory read of the new frame is back.
// The player stage sets the rate at one item per cycle; it pauses only while
// the output queue, counting the result still in flight, has no room left.
// Configuration writes are always ready.
module animation_frame_sequencer_top #(
    parameter int MAX_FRAMES = 64,
    parameter int TIME_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  afs_pkg::t_in_item  i_in,
    output logic               empty,
    input  logic               pop,
    output afs_pkg::t_out_item o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    localparam int OUT_W = $bits(afs_pkg::t_out_item);

    afs_pkg::t_cmd                   cmd;
    logic                            cmd_valid;
    logic                            cmd_take;
    logic                            res_valid;
    afs_pkg::t_out_item              res;
    logic [OUT_W-1:0]                out_data;
    logic                            out_full;
    logic [afs_pkg::OUT_CNT_W-1:0]   out_count;

    assign o_cfg_ready = 1'b1;

    afs_front #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_in),
        .o_full      (full),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_take  (cmd_take)
    );

    afs_back #(
        .MAX_FRAMES (MAX_FRAMES),
        .TIME_BITS  (TIME_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_take  (cmd_take),
        .i_out_count (out_count),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    afs_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (afs_pkg::OUT_Q_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid && !out_full),
        .i_data  (res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_data),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign o_out = afs_pkg::t_out_item'(out_data);

endmodule

[rtl/afs_checker.sv]
// Port-level checks for the animation frame sequencer top level.
// Depends on afs_pkg; bound to animation_frame_sequencer_top below.
module afs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input afs_pkg::t_out_item o_out,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_blank_when_hidden: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out.show) |->
        (o_out.pixel_word0 == 32'b0 && o_out.pixel_word1 == 32'b0 &&
         o_out.pixel_word2 == 32'b0))
        else $error("pixel words set on a result that is not shown");

    a_blank_unless_playing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.play_state != afs_pkg::PS_PLAYING) |->
        (o_out.pixel_word0 == 32'b0 && o_out.pixel_word1 == 32'b0 &&
         o_out.pixel_word2 == 32'b0))
        else $error("pixel words set while not playing");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && !full && push) |-> o_cfg_ready)
        else $error("configuration port stalled during traffic");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out)))
        else $error("waiting result changed or vanished");

endmodule

bind animation_frame_sequencer_top afs_checker u_afs_checker (.*);
